// ===== rtl/npcs_pkg.sv =====
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants of the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int XLATE_DEPTH   = 256;
   localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
   localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
   localparam int XADDR_W       = $clog2(XLATE_DEPTH);

   localparam int ACTION_W = 2;
   localparam int IDX_W    = 8;
   localparam int RGB_W    = 24;
   localparam int CHAN_W   = 8;
   localparam int SQ_W     = 2 * CHAN_W;
   localparam int DIST_W   = SQ_W + 2;
   localparam int SIZE_W   = 9;

   localparam int REQ_DATA_W = IDX_W + RGB_W + IDX_W;
   localparam int RSP_DATA_W = IDX_W + IDX_W + RGB_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [ACTION_W-1:0] ACT_PALETTE_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_XLATE_WRITE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY         = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSLATE_ENABLE = 1'b1;

   localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = SIZE_W'(256);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/nearest_palette_color_search.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// A write updates its memory when accepted; a query scans palette entries
// below size, stopping at an exact match: one palette read a cycle into a
// registered distance pipeline, then one read of palette and translation
// memory at the winning index. Writes go one per cycle while idle; a query
// blocks requests until its result is loaded; a held result stalls both.
// Reset initialises control and config registers; memories hold no reset.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
   input  logic                              clock,
   input  logic                              reset,
   // tuser: action[1:0]
   // tdata: entry_index[7:0], query_rgb[31:8], translated_value[39:32]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [npcs_pkg::ACTION_W-1:0]     req_tuser,
   input  logic [npcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tdata: result_index[7:0], raw_index[15:8], nearest_rgb[39:16]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [npcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [npcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [npcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import npcs_pkg::*;

   logic [RGB_W-1:0]   palette_mem [PALETTE_DEPTH];
   logic [IDX_W-1:0]   xlate_mem   [XLATE_DEPTH];

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  palette_size_ff;
   logic               translate_enable_ff;
   logic [RGB_W-1:0]   query_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   size_sat;

   logic [RGB_W-1:0]   pal_rd_ff;
   logic [IDX_W-1:0]   xlate_rd_ff;
   logic [ADDR_W-1:0]  pal_rd_addr;

   logic               v1_ff, v2_ff;
   logic [ADDR_W-1:0]  idx1_ff, idx2_ff;
   logic [SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SQ_W-1:0]    sq_r_in, sq_g_in, sq_b_in;
   logic [DIST_W-1:0]  cand_dist;
   logic [ADDR_W-1:0]  best_ff, best_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;

   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic               req_accept, start_query, issue, scan_done, rsp_load;
   logic               pal_we, xlate_we;
   logic [ACTION_W-1:0] req_action;
   logic [IDX_W-1:0]   req_entry;
   logic [RGB_W-1:0]   req_rgb;
   logic [IDX_W-1:0]   req_tval;

   assign req_action = req_tuser;
   assign req_entry  = req_tdata[IDX_W-1:0];
   assign req_rgb    = req_tdata[IDX_W +: RGB_W];
   assign req_tval   = req_tdata[IDX_W+RGB_W +: IDX_W];

   assign size_sat = (palette_size_ff > SIZE_W'(PALETTE_DEPTH)) ?
                     CNT_W'(PALETTE_DEPTH) : CNT_W'(palette_size_ff);

   assign req_accept  = req_tvalid && req_tready;
   assign start_query = req_accept && (req_action == ACT_QUERY);
   assign pal_we      = req_accept && (req_action == ACT_PALETTE_WRITE) &&
                        ({1'b0, req_entry} < (IDX_W+1)'(PALETTE_DEPTH));
   assign xlate_we    = req_accept && (req_action == ACT_XLATE_WRITE);
   assign scan_done   = ((cnt_ff == size_sat) && !v1_ff && !v2_ff) ||
                        (best_dist_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start_query) state_in = ST_SCAN;
         ST_SCAN:  if (scan_done) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_SCAN:  issue = !scan_done && (cnt_ff < size_sat);
         ST_FETCH: ;
         ST_DONE:  rsp_load = !rsp_valid_ff || rsp_tready;
         default:  ;
      endcase
   end

   assign pal_rd_addr = (state_ff == ST_SCAN) ? cnt_ff[ADDR_W-1:0] : best_ff;

   // memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (pal_we) begin
         palette_mem[req_entry[ADDR_W-1:0]] <= req_rgb;
      end
      pal_rd_ff <= palette_mem[pal_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (xlate_we) begin
         xlate_mem[req_entry[XADDR_W-1:0]] <= req_tval;
      end
      xlate_rd_ff <= xlate_mem[XADDR_W'(best_ff)];
   end

   // per-channel squared differences
   function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   assign sq_r_in = sq_diff(pal_rd_ff[0 +: CHAN_W],        query_ff[0 +: CHAN_W]);
   assign sq_g_in = sq_diff(pal_rd_ff[CHAN_W +: CHAN_W],   query_ff[CHAN_W +: CHAN_W]);
   assign sq_b_in = sq_diff(pal_rd_ff[2*CHAN_W +: CHAN_W], query_ff[2*CHAN_W +: CHAN_W]);
   assign cand_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   // keep the first strictly smaller distance
   always_comb begin
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      cnt_in       = cnt_ff;
      if (start_query) begin
         best_in      = '0;
         best_dist_in = '1;
         cnt_in       = '0;
      end else if (state_ff == ST_SCAN) begin
         if (issue) cnt_in = cnt_ff + 1'b1;
         if (v2_ff && (cand_dist < best_dist_ff)) begin
            best_in      = idx2_ff;
            best_dist_in = cand_dist;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         palette_size_ff     <= PALETTE_SIZE_RESET;
         translate_enable_ff <= 1'b0;
         v1_ff               <= 1'b0;
         v2_ff               <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         cnt_ff              <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff && (state_ff == ST_SCAN);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_PALETTE_SIZE:     palette_size_ff     <= csr_wdata;
               CSR_TRANSLATE_ENABLE: translate_enable_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_query) query_ff <= req_rgb;
      idx1_ff      <= cnt_ff[ADDR_W-1:0];
      idx2_ff      <= idx1_ff;
      sq_r_ff      <= sq_r_in;
      sq_g_ff      <= sq_g_in;
      sq_b_ff      <= sq_b_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      if (rsp_load) begin
         rsp_data_ff <= {pal_rd_ff, IDX_W'(best_ff),
                         translate_enable_ff ? xlate_rd_ff : IDX_W'(best_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= size_sat))
      else $error("scan counter beyond palette size");

   a_dist_monotone: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && $past(state_ff == ST_SCAN)) |->
      (best_dist_ff <= $past(best_dist_ff)))
      else $error("best distance grew during scan");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside result state");

   a_stage_idx: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && (state_ff == ST_SCAN)) |-> (CNT_W'(idx2_ff) < size_sat))
      else $error("pipeline index outside palette size");
`endif

endmodule
